### rtl/pso_pkg.sv
// Shared types and constants of the palette scanout path with text overlay.
// No dependencies; imported by the interfaces and by the core.
`default_nettype none
package pso_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int OVERLAY_COLUMNS = 60;
  localparam int GLYPH_ROWS      = 7;

  localparam int PAL_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COL_W = (OVERLAY_COLUMNS > 1) ? $clog2(OVERLAY_COLUMNS) : 1;
  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  // Text area origin; the black plate sits one pixel outside it.
  localparam int TEXT_X0 = 3;
  localparam int TEXT_Y0 = 3;

  localparam logic [8:0] TEXT_X_LO = 9'(TEXT_X0);
  localparam logic [8:0] TEXT_X_HI = 9'(TEXT_X0 + OVERLAY_COLUMNS);
  localparam logic [8:0] TEXT_Y_LO = 9'(TEXT_Y0);
  localparam logic [8:0] TEXT_Y_HI = 9'(TEXT_Y0 + GLYPH_ROWS);
  localparam logic [8:0] BOX_X_LO  = 9'(TEXT_X0 - 1);
  localparam logic [8:0] BOX_Y_LO  = 9'(TEXT_Y0 - 1);

  localparam logic [15:0] WHITE565 = 16'hFFFF;
  localparam logic [15:0] BLACK565 = 16'h0000;
  localparam logic [7:0]  RED_MASK   = 8'hF8;
  localparam logic [7:0]  GREEN_MASK = 8'hFC;

  typedef enum logic [1:0] {
    CMD_PALETTE = 2'd0,
    CMD_COLUMN  = 2'd1,
    CMD_PIXEL   = 2'd2,
    CMD_UNUSED  = 2'd3
  } pso_cmd_t;

  typedef struct packed {
    pso_cmd_t   command;
    logic [7:0] palette_slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] column_slot;
    logic [6:0] column_bits;
    logic [7:0] color_index;
    logic [7:0] src_x;
    logic [7:0] src_y;
  } pso_in_t;

  typedef struct packed {
    logic [15:0] pixel_color;
  } pso_out_t;

  function automatic logic [15:0] rgb_to_565(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [7:0] rm;
    logic [7:0] gm;
    rm = r & RED_MASK;
    gm = g & GREEN_MASK;
    return {rm[7:3], gm[7:2], b[7:3]};
  endfunction

endpackage
`default_nettype wire

### rtl/pso_if.sv
// Valid/ready channel interfaces for requests and results of the core.
// Depends on pso_pkg for the payload structs.
`default_nettype none
interface pso_in_if
  import pso_pkg::*;
();
  logic    valid;
  logic    ready;
  pso_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pso_out_if
  import pso_pkg::*;
();
  logic     valid;
  logic     ready;
  pso_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/palette_scanout_with_overlay_core.sv
// Indexed color to RGB565 pixel path with a loaded text overlay.
// Depends on pso_pkg and the channel interfaces in pso_if.sv.
`default_nettype none
//
//  channel   dir  handshake     payload
//  pix_in    in   valid/ready   pso_in_t  (palette write, column write, pixel)
//  pix_out   out  valid/ready   pso_out_t (pixel_color, one per pixel request)
//
//  One request per clock when the result side keeps up; a pixel result
//  passes the memory read, classify and output registers in turn.
//  Throughput is one request a cycle while pix_out does not stall.
//  rst clears the pipeline valid bits and the per-column overlay valid bits;
//  no clearing pass, the block takes requests on the cycle after reset.
//  A stall at pix_out freezes all stages; pix_in.ready drops with it.
module palette_scanout_with_overlay_core
  import pso_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  pso_in_if.sink     pix_in,
  pso_out_if.source  pix_out
);

  // Whole pipe moves together; the output register is the last stage.
  logic adv;
  logic accept;
  assign adv    = !pix_out.valid || pix_out.ready;
  assign accept = pix_in.valid && adv;
  assign pix_in.ready = adv;

  // ---------------------------------------------------------------
  // Storage: palette (no reset; the user must write an entry before it is
  // read, not enforced by the block) and the overlay bitmap with one valid bit per column so reset reads zero.
  // ---------------------------------------------------------------
  logic [15:0]           palette [PALETTE_ENTRIES];
  logic [GLYPH_ROWS-1:0] bitmap  [OVERLAY_COLUMNS];
  logic [OVERLAY_COLUMNS-1:0] col_valid;

  logic [8:0] pal_wslot9, pal_ridx9, col_wslot9;
  logic       pal_wr, col_wr, pal_rd_ok;
  logic [GLYPH_ROWS+6:0] col_bits_ext;
  assign pal_wslot9   = {1'b0, pix_in.data.palette_slot};
  assign pal_ridx9    = {1'b0, pix_in.data.color_index};
  assign col_wslot9   = {3'b000, pix_in.data.column_slot};
  assign col_bits_ext = {{GLYPH_ROWS{1'b0}}, pix_in.data.column_bits};
  assign pal_wr = accept && (pix_in.data.command == CMD_PALETTE) &&
                  (pal_wslot9 < 9'(PALETTE_ENTRIES));
  assign col_wr = accept && (pix_in.data.command == CMD_COLUMN) &&
                  (col_wslot9 < 9'(OVERLAY_COLUMNS));
  assign pal_rd_ok = pal_ridx9 < 9'(PALETTE_ENTRIES);

  // Overlay read address: column under the pixel, parked at 0 outside the text.
  logic [8:0] x9, colx9;
  logic       col_rd_ok;
  logic [COL_W-1:0] col_raddr;
  assign x9        = {1'b0, pix_in.data.src_x};
  assign colx9     = x9 - TEXT_X_LO;
  assign col_rd_ok = (x9 >= TEXT_X_LO) && (x9 < TEXT_X_HI);
  assign col_raddr = col_rd_ok ? colx9[COL_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      palette[pal_wslot9[PAL_W-1:0]] <= rgb_to_565(pix_in.data.red, pix_in.data.green,
                                                   pix_in.data.blue);
    end
    if (col_wr) begin
      bitmap[col_wslot9[COL_W-1:0]] <= col_bits_ext[GLYPH_ROWS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (col_wr) begin
      col_valid[col_wslot9[COL_W-1:0]] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: registered memory reads and coordinates.
  // ---------------------------------------------------------------
  logic                  s1_valid;
  logic [15:0]           s1_pal;
  logic                  s1_pal_ok;
  logic [GLYPH_ROWS-1:0] s1_word;
  logic                  s1_word_ok;
  logic [7:0]            s1_x, s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && (pix_in.data.command == CMD_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pal     <= palette[pix_in.data.color_index[PAL_W-1:0]];
      s1_pal_ok  <= pal_rd_ok;
      s1_word    <= bitmap[col_raddr];
      s1_word_ok <= col_valid[col_raddr];
      s1_x       <= pix_in.data.src_x;
      s1_y       <= pix_in.data.src_y;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: classify against the plate box and the text area.
  // ---------------------------------------------------------------
  logic [8:0] s1_x9, s1_y9, s1_row9;
  logic       in_box, in_text;
  assign s1_x9   = {1'b0, s1_x};
  assign s1_y9   = {1'b0, s1_y};
  assign s1_row9 = s1_y9 - TEXT_Y_LO;
  assign in_box  = (s1_x9 >= BOX_X_LO) && (s1_x9 <= TEXT_X_HI) &&
                   (s1_y9 >= BOX_Y_LO) && (s1_y9 <= TEXT_Y_HI);
  assign in_text = (s1_x9 >= TEXT_X_LO) && (s1_x9 < TEXT_X_HI) &&
                   (s1_y9 >= TEXT_Y_LO) && (s1_y9 < TEXT_Y_HI);

  logic        s2_valid;
  logic        s2_in_box;
  logic        s2_lit;
  logic        s2_pal_ok;
  logic [15:0] s2_pal;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_in_box <= in_box;
      s2_lit    <= in_text && s1_word_ok && s1_word[s1_row9[ROW_W-1:0]];
      s2_pal_ok <= s1_pal_ok;
      s2_pal    <= s1_pal;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: color select into the output register.
  // ---------------------------------------------------------------
  logic [15:0] color;
  always_comb begin
    if (s2_in_box) begin
      color = s2_lit ? WHITE565 : BLACK565;
    end else begin
      color = s2_pal_ok ? s2_pal : BLACK565;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      pix_out.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      pix_out.data.pixel_color <= color;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // Write and unused requests never enter the result pipe.
  a_no_result_for_write: assert property (@(posedge clk) disable iff (rst)
    (accept && pix_in.data.command != CMD_PIXEL) |=> !s1_valid)
    else $error("non-pixel request entered the pipe");

  // A pixel request always enters the pipe.
  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && pix_in.data.command == CMD_PIXEL) |=> s1_valid)
    else $error("pixel request lost at stage 1");

  // A stalled output freezes the inner stages.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1_valid) && $stable(s2_valid)))
    else $error("pipe moved during output stall");

  // Reset leaves the whole overlay reading as blank.
  a_bitmap_cleared: assert property (@(posedge clk)
    rst |=> (col_valid == '0))
    else $error("overlay valid bits not cleared by reset");

endmodule
`default_nettype wire
